### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk, off during rst
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/stbs_pkg.sv
package stbs_pkg;

  // fixed field widths
  localparam int DATA_W  = 32;
  localparam int SLOT_W  = 10;
  localparam int COUNT_W = 11;

  // default table size
  localparam int DEPTH_DEFAULT = 1024;

  // request kinds
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // input item
  typedef struct packed {
    logic                     req_type;
    logic [SLOT_W-1:0]        slot_index;
    logic signed [DATA_W-1:0] element_value;
    logic signed [DATA_W-1:0] search_key;
  } req_t;

  // result item
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] match_index;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic wr_en;
    logic init;
    logic issue;
    logic step;
    logic fin_hit;
    logic fin_miss;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic hit;
    logic next_empty;
  } dp_sts_t;

endpackage

### sv/sorted_table_binary_search_unit.sv
// Sorted table with binary search.
// Items enter on start/req and are taken when start is high and busy is low.
// A load item (req_type 0) writes element_value at slot_index as it is taken
// and gives no result; slots at or above the table depth are ignored.
// A search item (req_type 1) searches slots 0 to element_count-1, counts
// above the table depth being cut to the depth, and returns one result on
// result for one cycle, marked by done: found and the hit slot, or 0/0.
// The search loop makes one probe per cycle through the table's single
// memory read port; done is strobed when a probe hits or the range runs
// empty, and the next item can be taken in the done cycle. An empty table
// ends the search with a miss before any probe.
// The receiver cannot stall; each result must be taken in its done cycle.
// The user must write element_count through cfg_wen/cfg_wdata only while
// the block is idle, which it does not enforce. Reset clears the controller
// and element_count; table contents are undefined until loaded (only in idle).
module sorted_table_binary_search_unit
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  req_t               req,
  input  logic               cfg_wen,
  input  logic [COUNT_W-1:0] cfg_wdata,
  output logic               done,
  output rsp_t               result
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // sequencing of loads and the probe loop
  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req.req_type),
    .sts      (sts),
    .busy     (busy),
    .done     (done),
    .cmd      (cmd)
  );

  // table memory, search range and result
  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

endmodule

### sv/stbs_datapath.sv
`include "assert_macros.svh"

module stbs_datapath
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  req_t               req,
  input  logic               cfg_wen,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  ctl_cmd_t           cmd,
  output dp_sts_t            sts,
  output rsp_t               result
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;
  // one bit above the wider of slot and address so the depth itself fits
  localparam int SW = ((AW > SLOT_W) ? AW : SLOT_W) + 1;

  logic [DATA_W-1:0]        mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rd_data;
  logic signed [DATA_W-1:0] key;
  logic [COUNT_W-1:0]       element_count;
  logic [CW-1:0]            lo;
  logic [CW-1:0]            hi;
  logic [AW-1:0]            mid_q;

  logic [CW-1:0] count_sat;
  logic          slot_ok;
  logic [CW:0]   sum_cur;
  logic [AW-1:0] mid_cur;
  logic          key_lt;
  logic [CW-1:0] lo_next;
  logic [CW-1:0] hi_next;
  logic [CW:0]   sum_next;
  logic [AW-1:0] mid_next;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  // element count register
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
    end else if (cfg_wen) begin
      element_count <= cfg_wdata;
    end
  end

  // count saturated to the table size, load range check
  assign count_sat = (EW'(element_count) > EW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                             : CW'(element_count);
  assign slot_ok   = SW'(req.slot_index) < SW'(TABLE_DEPTH);

  // midpoint of the current range
  assign sum_cur = {1'b0, lo} + {1'b0, hi} - (CW + 1)'(1);
  assign mid_cur = sum_cur[AW:1];

  // compare probe with key and narrow the range
  assign key_lt  = key < rd_data;
  assign lo_next = key_lt ? lo : (CW'(mid_q) + CW'(1));
  assign hi_next = key_lt ? CW'(mid_q) : hi;
  assign sum_next = {1'b0, lo_next} + {1'b0, hi_next} - (CW + 1)'(1);
  assign mid_next = sum_next[AW:1];

  assign sts.empty      = lo >= hi;
  assign sts.hit        = key == rd_data;
  assign sts.next_empty = lo_next >= hi_next;

  assign rd_en   = cmd.issue | cmd.step;
  assign rd_addr = cmd.issue ? mid_cur : mid_next;

  // table memory, one write or one read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en && slot_ok) begin
      mem[AW'(req.slot_index)] <= req.element_value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // search range and probe slot
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      key <= req.search_key;
      lo  <= '0;
      hi  <= count_sat;
    end else if (cmd.step) begin
      lo <= lo_next;
      hi <= hi_next;
    end
    if (rd_en) begin
      mid_q <= rd_addr;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.fin_hit || cmd.fin_miss) begin
      result.found       <= cmd.fin_hit;
      result.match_index <= cmd.fin_hit ? SLOT_W'(mid_q) : '0;
    end
  end

  `ASSERT_SAME(a_issue_nonempty, cmd.issue, lo < hi, "probe issued on an empty range")
  `ASSERT_NEXT(a_probe_in_range, cmd.issue || cmd.step,
               (CW'(mid_q) >= lo) && (CW'(mid_q) < hi), "probe slot outside the range")
  `ASSERT_SAME(a_range_bounded, cmd.step, hi <= count_sat, "range end beyond the count")

endmodule

### sv/stbs_ctrl.sv
`include "assert_macros.svh"

module stbs_ctrl
  import stbs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     req_type,
  input  dp_sts_t  sts,
  output logic     busy,
  output logic     done,
  output ctl_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_PROBE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       done_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (req_type == REQ_SEARCH) begin
            cmd.init   = 1'b1;
            state_next = ST_ISSUE;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      ST_ISSUE: begin
        if (sts.empty) begin
          cmd.fin_miss = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          cmd.issue  = 1'b1;
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        priority if (sts.hit) begin
          cmd.fin_hit = 1'b1;
          state_next  = ST_IDLE;
        end else if (sts.next_empty) begin
          cmd.fin_miss = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign done_next = cmd.fin_hit | cmd.fin_miss;
  assign busy      = state != ST_IDLE;

  // state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  `ASSERT_SAME(a_done_idle, done, state == ST_IDLE, "result strobe while searching")
  `ASSERT_NEXT(a_hit_done, (state == ST_PROBE) && sts.hit, done && (state == ST_IDLE),
               "hit did not end the search")
  `ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0(cmd), "more than one command at once")

endmodule

### sim/sorted_table_binary_search_unit_tb.sv
module sorted_table_binary_search_unit_tb;
  import stbs_pkg::*;

  localparam int STALL_LIMIT   = 5000;
  localparam int ITEM_TARGET   = 1350;
  localparam int PHASE_ITEMS   = 110;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 16;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // expected search results, kept by replaying the table and count
  class search_scoreboard;
    logic signed [DATA_W-1:0] tbl [DEPTH_DEFAULT];
    int   wr_gen [DEPTH_DEFAULT];
    int   gen;
    int   elem_count;
    int   errors;
    rsp_t expected_q [$];

    function new();
      foreach (wr_gen[i]) wr_gen[i] = 0;
      gen = 1;
      elem_count = 0;
      errors = 0;
    endfunction

    // walk the probe path; returns the first slot older than min_gen, else -1
    function int lookup(input logic signed [DATA_W-1:0] key, input int min_gen,
                        output rsp_t res);
      int lo, hi, mid;
      res = '0;
      lo = 0;
      hi = (elem_count > DEPTH_DEFAULT) ? DEPTH_DEFAULT : elem_count;
      while (lo < hi) begin
        mid = lo + (hi - 1 - lo) / 2;
        if (wr_gen[mid] < min_gen) return mid;
        if (key < tbl[mid]) begin
          hi = mid;
        end else if (key > tbl[mid]) begin
          lo = mid + 1;
        end else begin
          res.found = 1'b1;
          res.match_index = SLOT_W'(mid);
          return -1;
        end
      end
      return -1;
    endfunction

    function void note_input(input req_t item);
      rsp_t res;
      if (item.req_type == REQ_LOAD) begin
        tbl[item.slot_index] = item.element_value;
        wr_gen[item.slot_index] = gen;
      end else begin
        void'(lookup(item.search_key, 0, res));
        expected_q.push_back(res);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(input rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result found=%0d slot=%0d with no search waiting",
                         got.found, got.match_index));
      end else begin
        want = expected_q.pop_front();
        if (got.found !== want.found)
          report($sformatf("found %0d, expected %0d", got.found, want.found));
        if (got.match_index !== want.match_index)
          report($sformatf("match_index %0d, expected %0d",
                           got.match_index, want.match_index));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  req_t               req = '0;
  logic               cfg_wen = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  logic               done;
  rsp_t               result;

  search_scoreboard sb;
  logic signed [DATA_W-1:0] plan [DEPTH_DEFAULT];
  int idle_pct = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  int idle_tab [4] = '{0, 73, 0, 23};

  sorted_table_binary_search_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .result    (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[sorted_table_binary_search_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ascending contents for this phase; slots are filled from here on demand
  function automatic void build_plan();
    longint v;
    longint step_max;
    case ($urandom_range(2))
      0: begin
        v = longint'($signed($urandom));
        step_max = 3;
      end
      1: begin
        v = -64'sd2147483648 + $urandom_range(0, 1 << 20);
        step_max = 1 << 21;
      end
      default: begin
        v = longint'($signed($urandom));
        step_max = 1 << 12;
      end
    endcase
    foreach (plan[i]) begin
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      plan[i] = v[DATA_W-1:0];
      v = v + $urandom_range(0, int'(step_max));
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] choose_key();
    int cnt, pick, idx;
    cnt  = (sb.elem_count > DEPTH_DEFAULT) ? DEPTH_DEFAULT : sb.elem_count;
    pick = $urandom_range(99);
    if (cnt == 0 || pick < 10) return $urandom;
    idx = $urandom_range(cnt - 1);
    if (pick < 65) return plan[idx];
    if (pick < 85) return $urandom_range(1) ? plan[idx] + 1 : plan[idx] - 1;
    if (pick < 92) return plan[0] - 1;
    if (pick < 96) return plan[cnt - 1] + 1;
    return $urandom_range(1) ? VAL_MIN : VAL_MAX;
  endfunction

  // one item through the start/busy handshake
  task automatic send_item(input req_t item);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(item);
    items_sent++;
  endtask

  task automatic load_item(input int slot, input logic signed [DATA_W-1:0] value);
    req_t item;
    item.req_type      = REQ_LOAD;
    item.slot_index    = SLOT_W'(slot);
    item.element_value = value;
    item.search_key    = $urandom;
    send_item(item);
  endtask

  // load every probed slot older than min_gen, then search
  task automatic search_for(input logic signed [DATA_W-1:0] key, input int min_gen);
    req_t item;
    rsp_t scratch;
    int   slot;
    slot = sb.lookup(key, min_gen, scratch);
    while (slot >= 0) begin
      load_item(slot, plan[slot]);
      slot = sb.lookup(key, min_gen, scratch);
    end
    item.req_type      = REQ_SEARCH;
    item.slot_index    = $urandom;
    item.element_value = $urandom;
    item.search_key    = key;
    send_item(item);
  endtask

  // let the block go idle before touching the count
  task automatic hold_off();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input int n);
    cfg_wen   <= 1'b1;
    cfg_wdata <= COUNT_W'(n);
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.elem_count = n;
  endtask

  // mostly sorted searches, some stray loads and loose searches
  task automatic random_item();
    int pick;
    int slot;
    pick = $urandom_range(99);
    slot = $urandom_range(DEPTH_DEFAULT - 1);
    if (pick < 70) search_for(choose_key(), sb.gen);
    else if (pick < 80) search_for($urandom_range(1) ? choose_key() : $urandom, 1);
    else if (pick < 92) load_item(slot, plan[slot]);
    else load_item(slot, $urandom);
  endtask

  initial begin
    int n;
    int phase_end;
    sb = new();
    build_plan();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table after reset
    search_for(32'sd0, sb.gen);
    hold_off();
    write_count(2);

    // field extremes at both ends
    load_item(0, VAL_MIN);
    load_item(DEPTH_DEFAULT - 1, VAL_MAX);
    load_item(1, VAL_MAX);
    search_for(VAL_MIN, sb.gen);
    search_for(VAL_MAX, sb.gen);
    search_for(32'sd0, sb.gen);
    search_for(-32'sd1, sb.gen);

    // unsorted pair: the probe sequence decides
    load_item(0, 32'sd5);
    load_item(1, -32'sd5);
    search_for(-32'sd5, sb.gen);
    search_for(32'sd5, sb.gen);

    // count above the depth saturates; last slot reachable
    hold_off();
    write_count((1 << COUNT_W) - 1);
    sb.gen++;
    search_for(plan[DEPTH_DEFAULT - 1], sb.gen);

    // random phases, each with its own count, contents and idling
    for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
      hold_off();
      if (ph == 0) n = DEPTH_DEFAULT;
      else if (ph == 1) n = 0;
      else if (ph == 2) n = 1;
      else if ($urandom_range(9) < 6) n = $urandom_range(2, 64);
      else if ($urandom_range(3) < 3) n = $urandom_range(65, DEPTH_DEFAULT);
      else n = $urandom_range(DEPTH_DEFAULT + 1, (1 << COUNT_W) - 1);
      write_count(n);
      sb.gen++;
      build_plan();
      idle_pct = idle_tab[ph % 4];
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) random_item();
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[sorted_table_binary_search_unit] OK");
    end else begin
      $display("[sorted_table_binary_search_unit] ERROR");
    end
    $finish;
  end

endmodule
